/* hw/rtl/vrt_pkg.sv */
// Package for the voxel ray traversal block: item codes, the queue entry
// type and shared widths. No dependencies.
package vrt_pkg;

    localparam int VOX_W    = 20;
    localparam int MAG_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int T_W      = 32;
    localparam int EXT_FRAC = 22;
    localparam int QDEPTH   = 2;

    localparam int DEF_COORD_FRAC_BITS = 12;
    localparam int DEF_T_FRAC_BITS     = 16;
    localparam logic [15:0] MAX_STEPS_RESET = 16'd1024;

    localparam logic [T_W-1:0] T_SAT = '1;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [1:0] KIND_LIMIT = 2'd3;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_ANSWER = 1'b1;

    localparam logic [1:0] SGN_NONE  = 2'd0;
    localparam logic [1:0] SGN_PLUS  = 2'd1;
    localparam logic [1:0] SGN_MINUS = 2'd3;

    typedef struct packed {
        logic                          action;
        logic                          occupied;
        logic [2:0][VOX_W-1:0]         vox;
        logic [2:0][MAG_W-1:0]         mag;
        logic [2:0]                    neg;
        logic [2:0][FRAC_W-1:0]        frac;
    } t_cmd;

endpackage

/* hw/rtl/vrt_queue.sv */
// Short command queue between the front and back parts.
// Depends on vrt_pkg for the entry type and depth.
module vrt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vrt_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vrt_pkg::t_cmd o_data
);
    import vrt_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd          r_mem [QDEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

/* hw/rtl/vrt_front.sv */
// Front part: accepts input items, forms the per-axis extent, sign, voxel and
// fraction, and builds one queue command. Depends on vrt_pkg.
module vrt_front #(
    parameter int COORD_FRAC_BITS = vrt_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                i_action,
    input  logic signed [31:0]  i_origin_x,
    input  logic signed [31:0]  i_origin_y,
    input  logic signed [31:0]  i_origin_z,
    input  logic signed [15:0]  i_dir_x,
    input  logic signed [15:0]  i_dir_y,
    input  logic signed [15:0]  i_dir_z,
    input  logic [15:0]         i_ray_length,
    input  logic                i_occupied,
    output vrt_pkg::t_cmd       o_cmd
);
    import vrt_pkg::*;

    logic signed [31:0] org [3];
    logic signed [15:0] dir [3];
    logic signed [32:0] prod [3];
    logic signed [63:0] org_ext [3];

    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    always_comb begin
        o_cmd.action   = i_action;
        o_cmd.occupied = i_occupied;
        for (int a = 0; a < 3; a++) begin
            prod[a]       = 33'(dir[a]) * $signed({17'd0, i_ray_length});
            org_ext[a]    = 64'(org[a]);
            o_cmd.vox[a]  = VOX_W'(org_ext[a] >>> COORD_FRAC_BITS);
            o_cmd.neg[a]  = prod[a][32];
            o_cmd.mag[a]  = prod[a][32] ? MAG_W'(-prod[a]) : MAG_W'(prod[a]);
            o_cmd.frac[a] = FRAC_W'(org[a][COORD_FRAC_BITS-1:0]);
        end
    end
endmodule

/* hw/rtl/vrt_div.sv */
// Restoring divider that forms the saturated tDelta, one quotient bit per
// cycle. Depends on vrt_pkg for widths and the saturation constant.
module vrt_div #(
    parameter int T_FRAC_BITS = vrt_pkg::DEF_T_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vrt_pkg::MAG_W-1:0] i_mag,
    output logic                      o_done,
    output logic [vrt_pkg::T_W-1:0]   o_quot
);
    import vrt_pkg::*;

    localparam int QW = T_FRAC_BITS + EXT_FRAC + 1;
    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [MAG_W:0]   r_rem;
    logic [MAG_W-1:0] r_mag;
    logic [QW-1:0]    r_q;
    logic [MAG_W:0]   n_rem;
    logic             n_ge;
    logic [63:0]      q_ext;

    always_comb begin
        n_rem = {r_rem[MAG_W-1:0], (r_cnt == CW'(QW))};
        n_ge  = (n_rem >= {1'b0, r_mag});
        q_ext = 64'(r_q);
        o_quot = (q_ext[63:T_W] != '0) ? T_SAT : q_ext[T_W-1:0];
    end

    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
            r_rem  <= '0;
            r_q    <= '0;
            r_mag  <= i_mag;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_ge ? n_rem - {1'b0, r_mag} : n_rem;
            r_q   <= {r_q[QW-2:0], n_ge};
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule

/* hw/rtl/vrt_back.sv */
// Back part: runs ray setup and DDA steps from queued commands and holds the
// result register. Depends on vrt_pkg and vrt_div.
module vrt_back #(
    parameter int COORD_FRAC_BITS = vrt_pkg::DEF_COORD_FRAC_BITS,
    parameter int T_FRAC_BITS     = vrt_pkg::DEF_T_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  vrt_pkg::t_cmd                     i_q_data,
    output logic                              o_q_pop,
    input  logic [15:0]                       i_max_steps,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_kind,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_x,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_y,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_z,
    output logic [1:0]                        o_normal_axis,
    output logic                              o_normal_negative
);
    import vrt_pkg::*;

    localparam int PW = T_W + COORD_FRAC_BITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_AXIS, S_DIV, S_MUL, S_SAT, S_STEP, S_CHK, S_OUT
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [1:0]           r_axis;
    logic [VOX_W-1:0]     r_vox [3];
    logic [T_W-1:0]       r_tmax [3];
    logic [T_W-1:0]       r_td [3];
    logic [1:0]           r_sgn [3];
    logic [2:0]           r_normal;
    logic [15:0]          r_steps;
    logic                 r_active;
    logic                 r_from_start;
    logic [PW-1:0]        r_prod;
    logic [1:0]           r_res_kind;
    logic                 r_res_vox;
    logic [2:0]           r_res_normal;

    logic                 div_start, div_done;
    logic [T_W-1:0]       div_quot;
    logic [COORD_FRAC_BITS:0] f_val;
    logic [PW-COORD_FRAC_BITS-1:0] prod_sh;
    logic [1:0]           sel;
    logic [T_W:0]         t_sum;
    logic                 past_end;

    vrt_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (r_cmd.mag[r_axis]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        div_start = (r_state == S_AXIS) && (r_cmd.mag[r_axis] != '0);
        o_q_pop   = (r_state == S_IDLE) && i_q_valid;
        f_val = r_cmd.neg[r_axis]
              ? (COORD_FRAC_BITS+1)'(r_cmd.frac[r_axis][COORD_FRAC_BITS-1:0])
              : (COORD_FRAC_BITS+1)'(1 << COORD_FRAC_BITS)
                - (COORD_FRAC_BITS+1)'(r_cmd.frac[r_axis][COORD_FRAC_BITS-1:0]);
        prod_sh = r_prod[PW-1:COORD_FRAC_BITS];
        if (r_tmax[0] < r_tmax[1]) begin
            sel = (r_tmax[0] < r_tmax[2]) ? 2'd0 : 2'd2;
        end else begin
            sel = (r_tmax[1] < r_tmax[2]) ? 2'd1 : 2'd2;
        end
        t_sum    = {1'b0, r_tmax[sel]} + {1'b0, r_td[sel]};
        past_end = (r_tmax[0] > T_ONE) && (r_tmax[1] > T_ONE) && (r_tmax[2] > T_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_axis      <= '0;
            r_normal    <= '0;
            r_steps     <= '0;
            o_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_vox[a]  <= '0;
                r_tmax[a] <= '0;
                r_td[a]   <= '0;
                r_sgn[a]  <= SGN_NONE;
            end
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_data;
                        if (i_q_data.action == ACT_START) begin
                            for (int a = 0; a < 3; a++) begin
                                r_vox[a] <= i_q_data.vox[a];
                            end
                            r_axis       <= '0;
                            r_normal     <= '0;
                            r_steps      <= '0;
                            r_from_start <= 1'b1;
                            r_state      <= S_AXIS;
                        end else if (r_active) begin
                            if (i_q_data.occupied) begin
                                r_active     <= 1'b0;
                                r_res_kind   <= KIND_HIT;
                                r_res_vox    <= 1'b1;
                                r_res_normal <= r_normal;
                                r_state      <= S_OUT;
                            end else begin
                                r_from_start <= 1'b0;
                                r_state      <= S_STEP;
                            end
                        end
                    end
                end
                S_AXIS: begin
                    if (r_cmd.mag[r_axis] == '0) begin
                        r_sgn[r_axis]  <= SGN_NONE;
                        r_td[r_axis]   <= T_SAT;
                        r_tmax[r_axis] <= T_SAT;
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd2) ? S_CHK : S_AXIS;
                    end else begin
                        r_sgn[r_axis] <= r_cmd.neg[r_axis] ? SGN_MINUS : SGN_PLUS;
                        r_state       <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_td[r_axis] <= div_quot;
                        r_state      <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_td[r_axis]) * PW'(f_val);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_tmax[r_axis] <= (prod_sh[T_W] == 1'b1) ? T_SAT : prod_sh[T_W-1:0];
                    r_axis  <= r_axis + 1'b1;
                    r_state <= (r_axis == 2'd2) ? S_CHK : S_AXIS;
                end
                S_STEP: begin
                    if (r_sgn[sel] == SGN_PLUS) begin
                        r_vox[sel] <= r_vox[sel] + 1'b1;
                    end else if (r_sgn[sel] == SGN_MINUS) begin
                        r_vox[sel] <= r_vox[sel] - 1'b1;
                    end
                    r_tmax[sel] <= t_sum[T_W] ? T_SAT : t_sum[T_W-1:0];
                    if (r_sgn[sel] == SGN_NONE) begin
                        r_normal <= '0;
                    end else begin
                        r_normal <= {r_sgn[sel] == SGN_PLUS, sel + 2'd1};
                    end
                    if (r_steps != '1) begin
                        r_steps <= r_steps + 1'b1;
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_res_normal <= '0;
                    if (past_end) begin
                        r_active   <= 1'b0;
                        r_res_kind <= KIND_MISS;
                        r_res_vox  <= 1'b0;
                    end else if (!r_from_start && r_steps >= i_max_steps) begin
                        r_active   <= 1'b0;
                        r_res_kind <= KIND_LIMIT;
                        r_res_vox  <= 1'b0;
                    end else begin
                        r_active   <= 1'b1;
                        r_res_kind <= KIND_QUERY;
                        r_res_vox  <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid       <= 1'b1;
                        o_kind            <= r_res_kind;
                        o_voxel_x         <= r_res_vox ? r_vox[0] : '0;
                        o_voxel_y         <= r_res_vox ? r_vox[1] : '0;
                        o_voxel_z         <= r_res_vox ? r_vox[2] : '0;
                        o_normal_axis     <= r_res_normal[1:0];
                        o_normal_negative <= r_res_normal[2];
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_normal_hit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_HIT |-> o_normal_axis == 2'd0 && !o_normal_negative)
        else $error("normal set outside a hit");
    a_end_no_voxel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_MISS || o_kind == KIND_LIMIT)
        |-> o_voxel_x == '0 && o_voxel_y == '0 && o_voxel_z == '0)
        else $error("voxel fields set in a miss or limit result");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_active && r_state == S_IDLE)
        else $error("block not idle after reset");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside setup");
`endif
endmodule

/* hw/rtl/voxel_ray_traversal.sv */
// Three-dimensional voxel ray traversal (DDA) with fixed-point setup.
// A start item forms tDelta per axis in the one-bit-per-cycle divider shared
// by the three axes; an axis with zero extent skips the divider. A void
// occupancy answer passes through queue pop, step, end check and the load
// of the result register. A solid answer passes through queue pop and the
// load of the result register. A command queue of two entries sits between
// the input side and the traversal sequencer. Depends on vrt_pkg, vrt_front,
// vrt_queue and vrt_back.
module voxel_ray_traversal #(
    parameter int COORD_FRAC_BITS = vrt_pkg::DEF_COORD_FRAC_BITS,
    parameter int T_FRAC_BITS     = vrt_pkg::DEF_T_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic signed [31:0]                i_origin_x,
    input  logic signed [31:0]                i_origin_y,
    input  logic signed [31:0]                i_origin_z,
    input  logic signed [15:0]                i_dir_x,
    input  logic signed [15:0]                i_dir_y,
    input  logic signed [15:0]                i_dir_z,
    input  logic [15:0]                       i_ray_length,
    input  logic                              i_occupied,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_kind,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_x,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_y,
    output logic signed [vrt_pkg::VOX_W-1:0]  o_voxel_z,
    output logic [1:0]                        o_normal_axis,
    output logic                              o_normal_negative
);
    import vrt_pkg::*;

    t_cmd        front_cmd, q_cmd;
    logic        q_full, q_valid, q_pop;
    logic [15:0] r_max_steps;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= MAX_STEPS_RESET;
        end else if (i_cfg_valid) begin
            r_max_steps <= i_cfg_data;
        end
    end

    vrt_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .i_action     (i_action),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_origin_z   (i_origin_z),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .i_ray_length (i_ray_length),
        .i_occupied   (i_occupied),
        .o_cmd        (front_cmd)
    );

    vrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    vrt_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .T_FRAC_BITS     (T_FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_cmd),
        .o_q_pop           (q_pop),
        .i_max_steps       (r_max_steps),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_voxel_x         (o_voxel_x),
        .o_voxel_y         (o_voxel_y),
        .o_voxel_z         (o_voxel_z),
        .o_normal_axis     (o_normal_axis),
        .o_normal_negative (o_normal_negative)
    );
endmodule
